FILE: hw/rtl/rhd_pkg.sv
package rhd_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 4096;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;

	localparam int unsigned DIM_W   = 13;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned PAIR_W  = CH_W + 1;
	localparam int unsigned NUM_CH  = 4;
	localparam int unsigned ENTRY_W = NUM_CH * PAIR_W;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// how the result stage forms the output pixel
	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_PAIR = 2'd1;
	localparam logic [1:0] KIND_QUAD = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
		logic            frame_end;
		logic            size_error;
	} pixel_out_t;

	function automatic int unsigned addr_bits(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int unsigned maxv);
		logic [31:0] max_bits;
		max_bits = maxv;
		if (v == '0)
			return DIM_W'(1);
		if (32'(v) > max_bits)
			return max_bits[DIM_W-1:0];
		return v;
	endfunction

endpackage

FILE: hw/rtl/rgba_half_downsample_unit.sv
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+--------------------------------
// pixel    | pixel_valid in,  pixel_stall out | pixel  (pixel_in_t), raster order
// result   | result_valid out, result_stall in| result (pixel_out_t)
// cfg      | cfg_valid in,    cfg_ready out   | cfg_index, cfg_data (13 bits used)
//
// One pixel is taken per clock while pixel_stall is low. A pixel that yields a
// result passes through the s1 register (line buffer read) and then the result
// register, from which it leaves when result_stall is low.
// Reset clears counters, held pixel and valid flags; sizes return to 2x2.
// The line buffer has no reset: it is always written before it is read.
// pixel_stall rises only when s1 holds a result that cannot move on.
module rgba_half_downsample_unit import rhd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  pixel_in_t            pixel,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pixel_out_t           result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int unsigned CW         = addr_bits(MAX_WIDTH);
	localparam int unsigned RW         = addr_bits(MAX_HEIGHT);
	localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int unsigned AW         = addr_bits(LINE_DEPTH);

	// configuration and position
	logic [DIM_W-1:0] image_width_q, image_height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [NUM_CH-1:0][CH_W-1:0] held_q;

	// s1 stage
	logic                          valid_s1;
	logic [1:0]                    kind_s1;
	logic [NUM_CH-1:0][PAIR_W-1:0] sum_s1;
	logic                          frame_end_s1;

	// result register
	pixel_out_t result_q;
	logic       result_valid_q;

	logic [DIM_W-1:0] width_eff, height_eff;
	logic last_col, last_row, last, size_err, one_w, one_h;
	logic [NUM_CH-1:0][CH_W-1:0]   px;
	logic [NUM_CH-1:0][PAIR_W-1:0] pair;
	logic emit, hold_en, ram_we, ram_re;
	logic [1:0] kind;
	logic [NUM_CH-1:0][PAIR_W-1:0] sum_in;
	logic [CW-1:0] col_half;
	logic [AW-1:0] slot;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [NUM_CH-1:0][PAIR_W-1:0] line_sum;
	logic out_load, s1_adv, accept, cfg_we;
	logic [NUM_CH-1:0][CH_W-1:0] out_px;
	pixel_out_t out_next;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign width_eff  = clamp_dim(image_width_q, MAX_WIDTH);
	assign height_eff = clamp_dim(image_height_q, MAX_HEIGHT);

	assign last_col = (32'(col_q) + 32'd1) == 32'(width_eff);
	assign last_row = (32'(row_q) + 32'd1) == 32'(height_eff);
	assign last     = last_col && last_row;
	assign one_w    = width_eff == DIM_W'(1);
	assign one_h    = height_eff == DIM_W'(1);
	// an odd size other than one cannot be halved
	assign size_err = (width_eff[0] && !one_w) || (height_eff[0] && !one_h);

	assign px = {pixel.red, pixel.green, pixel.blue, pixel.alpha};

	always_comb begin
		for (int c = 0; c < NUM_CH; c++)
			pair[c] = {1'b0, held_q[c]} + {1'b0, px[c]};
	end

	// Decide what this pixel does: hold it, write a pair sum to the line,
	// or produce a result.
	always_comb begin
		emit    = 1'b0;
		hold_en = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		kind    = KIND_PAIR;
		sum_in  = pair;
		if (size_err) begin
			emit = last;
			kind = KIND_ERR;
		end else if (one_w && one_h) begin
			emit = 1'b1;
			kind = KIND_PASS;
			for (int c = 0; c < NUM_CH; c++)
				sum_in[c] = {1'b0, px[c]};
		end else if (one_w || one_h) begin
			// single row pairs along columns, single column pairs along rows
			if (one_h ? col_q[0] : row_q[0])
				emit = 1'b1;
			else
				hold_en = 1'b1;
		end else begin
			if (!col_q[0])
				hold_en = 1'b1;
			else if (!row_q[0])
				ram_we = 1'b1;
			else begin
				emit   = 1'b1;
				ram_re = 1'b1;
				kind   = KIND_QUAD;
			end
		end
	end

	assign col_half = col_q >> 1;
	assign slot     = AW'(col_half);

	// Handshake: the result register frees s1, s1 frees the input.
	assign out_load    = !result_valid_q || !result_stall;
	assign s1_adv      = valid_s1 && out_load;
	assign pixel_stall = valid_s1 && !out_load;
	assign accept      = pixel_valid && !pixel_stall;

	// Line of horizontal pair sums; even rows write, odd rows read the same slot.
	rhd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (accept && ram_we),
		.waddr(slot),
		.wdata(pair),
		.re   (accept && ram_re),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	assign line_sum = ram_rdata;

	// Finish the result from the s1 sum and, for 2x2 blocks, the line entry.
	always_comb begin
		logic [PAIR_W:0] quad;
		quad = '0;
		out_px = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			quad = {1'b0, sum_s1[c]} + {1'b0, line_sum[c]};
			case (kind_s1)
				KIND_PASS: out_px[c] = sum_s1[c][CH_W-1:0];
				KIND_PAIR: out_px[c] = sum_s1[c][PAIR_W-1:1];
				KIND_QUAD: out_px[c] = quad[PAIR_W:2];
				default:   out_px[c] = '0;
			endcase
		end
		out_next.out_red    = out_px[3];
		out_next.out_green  = out_px[2];
		out_next.out_blue   = out_px[1];
		out_next.out_alpha  = out_px[0];
		out_next.frame_end  = frame_end_s1;
		out_next.size_error = kind_s1 == KIND_ERR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(2);
			image_height_q <= DIM_W'(2);
			col_q          <= '0;
			row_q          <= '0;
			held_q         <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
				// any size write restarts the frame
				if (cfg_index == REG_IMAGE_WIDTH)
					image_width_q <= cfg_data;
				else
					image_height_q <= cfg_data;
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else
					col_q <= col_q + CW'(1);
			end
			if (accept && hold_en)
				held_q <= px;
			if (accept && emit)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (out_load)
				result_valid_q <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_s1      <= kind;
			sum_s1       <= sum_in;
			frame_end_s1 <= last;
		end
		if (s1_adv)
			result_q <= out_next;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && ram_we && ram_re))
		else $error("line buffer read and write in one cycle");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> valid_s1 && result_valid_q)
		else $error("input stalled with room in the pipeline");

	a_s1_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> result_valid_q)
		else $error("s1 advanced without loading the result register");

	a_err_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.size_error |-> result_q.frame_end)
		else $error("size error result without frame end");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(width_eff) && 32'(row_q) < 32'(height_eff))
		else $error("position counter beyond image size");
`endif

endmodule

FILE: hw/rtl/rhd_ram.sv
module rhd_ram import rhd_pkg::*; #(
	parameter int unsigned WIDTH = ENTRY_W,
	parameter int unsigned DEPTH = MAX_WIDTH_DEF / 2
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [addr_bits(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]              wdata,
	input  logic                          re,
	input  logic [addr_bits(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
